// File: rtl/chd_pkg.sv
// Shared types, codes and helpers for the chunked body decoder.
package chd_pkg;

    localparam int unsigned LINE_CHARS_MAX = 8;
    localparam logic [7:0]  CR_BYTE        = 8'h0D;
    localparam logic [7:0]  LF_BYTE        = 8'h0A;
    localparam logic        OP_DATA        = 1'b0;
    localparam logic        OP_END         = 1'b1;

    typedef enum logic [2:0] {
        PH_LENGTH  = 3'd0,
        PH_CONTENT = 3'd1,
        PH_TRAILER = 3'd2,
        PH_DONE    = 3'd3,
        PH_ERROR   = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        KIND_CONTENT = 2'd0,
        KIND_DONE    = 2'd1,
        KIND_ERROR   = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ERR_LINE_LONG  = 2'd0,
        ERR_BAD_HEX    = 2'd1,
        ERR_SIZE_LIMIT = 2'd2,
        ERR_EARLY_END  = 2'd3
    } err_t;

    typedef struct packed {
        phase_t      phase;
        logic [31:0] length_acc;
        logic [3:0]  char_count;
        logic        pending_cr;
        logic [31:0] bytes_remaining;
        logic        last_chunk;
        logic        trailer_idx;
        logic [31:0] total_counted;
    } dec_state_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  content_byte;
        err_t        error_code;
    } result_t;

    typedef struct packed {
        logic    valid;
        result_t data;
    } result_slot_t;

    // Bit 4 set when c is a hex digit of either case, low bits hold its value.
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c inside {[8'h30:8'h39]})
        begin
            r = {1'b1, c[3:0]};
        end
        else if (c inside {[8'h41:8'h46], [8'h61:8'h66]})
        begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

endpackage

// File: rtl/chd_in_if.sv
// Input byte channel: valid/ready handshake with operation and data byte.
interface chd_in_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] data_byte;

    modport source (output valid, output operation, output data_byte, input ready);
    modport sink   (input valid, input operation, input data_byte, output ready);
endinterface

// File: rtl/chd_out_if.sv
// Result channel: valid/ready handshake with kind, content byte and error code.
interface chd_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] content_byte;
    logic [1:0] error_code;

    modport source (output valid, output kind, output content_byte, output error_code,
                    input ready);
    modport sink   (input valid, input kind, input content_byte, input error_code,
                    output ready);
endinterface

// File: rtl/chd_step.sv
// Single-item decode step: next decoder state and optional result from one item.
module chd_step
(
    input  chd_pkg::dec_state_t   cur,
    input  logic                  operation,
    input  logic [7:0]            data_byte,
    input  logic [31:0]           max_total_bytes,
    output chd_pkg::dec_state_t   nxt,
    output chd_pkg::result_slot_t res
);
    import chd_pkg::*;

    logic [4:0] hex;
    logic       line_full;

    assign hex       = hex_decode(data_byte);
    assign line_full = (cur.char_count >= 4'(LINE_CHARS_MAX));

    always_comb
    begin
        nxt                   = cur;
        res.valid             = 1'b0;
        res.data.kind         = KIND_CONTENT;
        res.data.content_byte = 8'd0;
        res.data.error_code   = ERR_LINE_LONG;

        case (cur.phase)
            PH_LENGTH, PH_CONTENT, PH_TRAILER:
            begin
                if (operation == OP_END)
                begin
                    nxt.phase           = PH_ERROR;
                    res.valid           = 1'b1;
                    res.data.kind       = KIND_ERROR;
                    res.data.error_code = ERR_EARLY_END;
                end
                else if (cur.phase == PH_LENGTH)
                begin
                    if (cur.pending_cr)
                    begin
                        nxt.pending_cr = 1'b0;
                        if (data_byte == LF_BYTE)
                        begin
                            nxt.bytes_remaining = cur.length_acc;
                            nxt.last_chunk      = (cur.length_acc == 32'd0);
                            nxt.length_acc      = 32'd0;
                            nxt.char_count      = 4'd0;
                            nxt.trailer_idx     = 1'b0;
                            nxt.phase = (cur.length_acc == 32'd0) ? PH_TRAILER : PH_CONTENT;
                        end
                        else
                        begin
                            // a stray CR is a line character and never a hex digit
                            nxt.phase           = PH_ERROR;
                            res.valid           = 1'b1;
                            res.data.kind       = KIND_ERROR;
                            res.data.error_code = line_full ? ERR_LINE_LONG : ERR_BAD_HEX;
                        end
                    end
                    else if (data_byte == CR_BYTE)
                    begin
                        nxt.pending_cr = 1'b1;
                    end
                    else if (line_full || !hex[4])
                    begin
                        nxt.phase           = PH_ERROR;
                        res.valid           = 1'b1;
                        res.data.kind       = KIND_ERROR;
                        res.data.error_code = line_full ? ERR_LINE_LONG : ERR_BAD_HEX;
                    end
                    else
                    begin
                        nxt.length_acc = {cur.length_acc[27:0], hex[3:0]};
                        nxt.char_count = cur.char_count + 4'd1;
                    end
                end
                else if (cur.phase == PH_CONTENT)
                begin
                    if (cur.total_counted >= max_total_bytes)
                    begin
                        nxt.phase           = PH_ERROR;
                        res.valid           = 1'b1;
                        res.data.kind       = KIND_ERROR;
                        res.data.error_code = ERR_SIZE_LIMIT;
                    end
                    else
                    begin
                        nxt.total_counted     = cur.total_counted + 32'd1;
                        nxt.bytes_remaining   = cur.bytes_remaining - 32'd1;
                        res.valid             = 1'b1;
                        res.data.kind         = KIND_CONTENT;
                        res.data.content_byte = data_byte;
                        if (cur.bytes_remaining == 32'd1)
                        begin
                            nxt.trailer_idx = 1'b0;
                            nxt.phase       = PH_TRAILER;
                        end
                    end
                end
                else
                begin
                    // trailing pair: count with saturation, no check
                    if (cur.total_counted != 32'hFFFF_FFFF)
                    begin
                        nxt.total_counted = cur.total_counted + 32'd1;
                    end
                    nxt.trailer_idx = ~cur.trailer_idx;
                    if (cur.trailer_idx)
                    begin
                        if (cur.last_chunk)
                        begin
                            nxt.phase     = PH_DONE;
                            res.valid     = 1'b1;
                            res.data.kind = KIND_DONE;
                        end
                        else
                        begin
                            nxt.phase = PH_LENGTH;
                        end
                    end
                end
            end
            default:
            begin
                // done, error and unused codes: drop the item
                nxt = cur;
            end
        endcase
    end

endmodule

// File: rtl/chd_out_buf.sv
// Two-entry result buffer: output register plus skid register.
module chd_out_buf
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  chd_pkg::result_slot_t push,
    output logic                  has_room,
    output logic                  out_valid,
    output chd_pkg::result_t      out_data,
    input  logic                  out_ready
);
    import chd_pkg::*;

    logic    main_valid_reg;
    logic    skid_valid_reg;
    result_t main_reg;
    result_t main_next;
    result_t skid_reg;
    logic    pop;

    assign pop       = main_valid_reg && out_ready;
    assign has_room  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    always_comb
    begin
        main_next = main_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                main_next = skid_reg;
            end
        end
        else if (push.valid && (!main_valid_reg || pop))
        begin
            main_next = push.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push.valid)
        begin
            if (main_valid_reg && !pop)
            begin
                skid_valid_reg <= 1'b1;
            end
            main_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            main_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        if (!skid_valid_reg && push.valid && main_valid_reg && !pop)
        begin
            skid_reg <= push.data;
        end
    end

    // hold the main entry while it stalls with the skid entry behind it
    a_skid_needs_main: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid entry held without a main entry");

    a_main_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (main_valid_reg && !out_ready) |=> (main_valid_reg && $stable(main_reg)))
        else $error("stalled result changed");

endmodule

// File: rtl/http_chunked_decoder_top.sv
// Top level of the HTTP chunked body decoder.
//
//  channel        | dir | handshake      | payload
//  ---------------+-----+----------------+-------------------------------------
//  byte_stream    | in  | valid/ready    | operation, data_byte
//  result_stream  | out | valid/ready    | kind, content_byte, error_code
//  cfg_wr_*       | in  | write enable   | max_total_bytes (32 bit)
//
// One item per cycle while the buffer has room: the decode step sits between the state registers
// and the result buffer, so an item's result is registered into the buffer when the item is taken.
// The two-entry result buffer keeps items flowing while one result stalls;
// ready drops only when both entries are full.
// Reset (rst_n low, asynchronous) returns to the length line with zero counts
// and max_total_bytes at all ones.
module http_chunked_decoder_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    chd_in_if.sink      byte_stream,
    chd_out_if.source   result_stream
);
    import chd_pkg::*;

    dec_state_t   state_reg;
    dec_state_t   state_next;
    logic [31:0]  max_total_reg;
    result_slot_t step_res;
    result_slot_t push;
    result_t      out_data;
    logic         has_room;
    logic         accept;

    assign byte_stream.ready = has_room;
    assign accept            = byte_stream.valid && has_room;

    chd_step u_step
    (
        .cur             (state_reg),
        .operation       (byte_stream.operation),
        .data_byte       (byte_stream.data_byte),
        .max_total_bytes (max_total_reg),
        .nxt             (state_next),
        .res             (step_res)
    );

    assign push.valid = accept && step_res.valid;
    assign push.data  = step_res.data;

    chd_out_buf u_out_buf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .has_room  (has_room),
        .out_valid (result_stream.valid),
        .out_data  (out_data),
        .out_ready (result_stream.ready)
    );

    assign result_stream.kind         = out_data.kind;
    assign result_stream.content_byte = out_data.content_byte;
    assign result_stream.error_code   = out_data.error_code;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase           <= PH_LENGTH;
            state_reg.length_acc      <= 32'd0;
            state_reg.char_count      <= 4'd0;
            state_reg.pending_cr      <= 1'b0;
            state_reg.bytes_remaining <= 32'd0;
            state_reg.last_chunk      <= 1'b0;
            state_reg.trailer_idx     <= 1'b0;
            state_reg.total_counted   <= 32'd0;
        end
        else if (accept)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_total_reg <= 32'hFFFF_FFFF;
        end
        else if (cfg_wr_en)
        begin
            max_total_reg <= cfg_wr_data;
        end
    end

    a_terminal_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.phase == PH_DONE || state_reg.phase == PH_ERROR)
        |=> $stable(state_reg.phase))
        else $error("left a terminal phase");

    a_line_len: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.char_count <= 4'(LINE_CHARS_MAX))
        else $error("length line count overran");

    a_content_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.phase == PH_CONTENT) |-> (state_reg.bytes_remaining != 32'd0))
        else $error("content phase with nothing left");

    // an early end right after a CR leaves the flag set in the error phase
    a_cr_only_in_line: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.pending_cr |-> (state_reg.phase == PH_LENGTH ||
                                  state_reg.phase == PH_ERROR))
        else $error("pending CR outside the length line");

endmodule

// File: test/tb_http_chunked_decoder_top.sv
// Testbench for the chunked body decoder: random chunk streams checked against a local decoder.
`timescale 1ns / 1ps

module tb_http_chunked_decoder_top;
    import chd_pkg::*;

    typedef struct packed {
        logic       op;
        logic [7:0] data;
    } byte_item_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [31:0] cfg_wr_data = 32'd0;
    logic        sink_hold = 1'b0;

    chd_in_if  byte_if ();
    chd_out_if res_if ();

    http_chunked_decoder_top i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .byte_stream   (byte_if),
        .result_stream (res_if)
    );

    // Local decoder state and its copy of the byte limit
    phase_t      dec_phase = PH_LENGTH;
    logic [31:0] len_acc = 32'd0;
    logic [3:0]  len_chars = 4'd0;
    logic        cr_seen = 1'b0;
    logic [31:0] chunk_left = 32'd0;
    logic        final_chunk = 1'b0;
    logic        pair_second = 1'b0;
    logic [31:0] body_count = 32'd0;
    logic [31:0] limit_cfg = 32'hFFFF_FFFF;

    byte_item_t feed_q[$];
    result_t    expected_results[$];

    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    int items_queued = 0;
    int items_taken = 0;
    int results_seen = 0;
    int mismatch_count = 0;
    int limit_writes = 0;

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    task automatic report_mismatch(input string msg);
        if (mismatch_count < 50)
            $display("MISMATCH @%0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    function automatic int hex_val(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39)
            return int'(c) - 'h30;
        if (c >= 8'h61 && c <= 8'h66)
            return int'(c) - 'h61 + 10;
        if (c >= 8'h41 && c <= 8'h46)
            return int'(c) - 'h41 + 10;
        return -1;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n, input logic upper);
        if (n < 4'd10)
            return 8'h30 + n;
        return (upper ? 8'h41 : 8'h61) + n - 8'd10;
    endfunction

    // Add one character to the length line; returns 1 on error with its code
    function automatic logic line_char_bad(input logic [7:0] c, output err_t code);
        int v;
        v = hex_val(c);
        code = ERR_LINE_LONG;
        if (len_chars >= LINE_CHARS_MAX)
            return 1'b1;
        if (v < 0)
        begin
            code = ERR_BAD_HEX;
            return 1'b1;
        end
        len_acc = {len_acc[27:0], v[3:0]};
        len_chars++;
        return 1'b0;
    endfunction

    task automatic push_result(input kind_t k, input logic [7:0] b, input err_t e);
        result_t r;
        r.kind = k;
        r.content_byte = b;
        r.error_code = e;
        expected_results.push_back(r);
    endtask

    // Error code field reads zero unless the kind is an error
    task automatic raise_error(input err_t e);
        dec_phase = PH_ERROR;
        push_result(KIND_ERROR, 8'h00, e);
    endtask

    task automatic step_decoder(input logic op, input logic [7:0] b);
        err_t code;
        if (!(dec_phase inside {PH_LENGTH, PH_CONTENT, PH_TRAILER}))
            return;
        if (op == OP_END)
        begin
            raise_error(ERR_EARLY_END);
            return;
        end
        case (dec_phase)
            PH_LENGTH:
            begin
                if (cr_seen)
                begin
                    cr_seen = 1'b0;
                    if (b == LF_BYTE)
                    begin
                        chunk_left = len_acc;
                        final_chunk = (len_acc == 32'd0);
                        len_acc = 32'd0;
                        len_chars = 4'd0;
                        pair_second = 1'b0;
                        dec_phase = final_chunk ? PH_TRAILER : PH_CONTENT;
                        return;
                    end
                    // a lone CR is a line character, then the new byte follows
                    if (line_char_bad(CR_BYTE, code))
                    begin
                        raise_error(code);
                        return;
                    end
                end
                if (b == CR_BYTE)
                    cr_seen = 1'b1;
                else if (line_char_bad(b, code))
                    raise_error(code);
            end
            PH_CONTENT:
            begin
                if ({1'b0, body_count} + 33'd1 > {1'b0, limit_cfg})
                begin
                    raise_error(ERR_SIZE_LIMIT);
                end
                else
                begin
                    body_count++;
                    chunk_left--;
                    if (chunk_left == 32'd0)
                    begin
                        pair_second = 1'b0;
                        dec_phase = PH_TRAILER;
                    end
                    push_result(KIND_CONTENT, b, ERR_LINE_LONG);
                end
            end
            default:
            begin
                if (body_count != 32'hFFFF_FFFF)
                    body_count++;
                if (!pair_second)
                begin
                    pair_second = 1'b1;
                end
                else
                begin
                    pair_second = 1'b0;
                    if (final_chunk)
                    begin
                        dec_phase = PH_DONE;
                        push_result(KIND_DONE, 8'h00, ERR_LINE_LONG);
                    end
                    else
                    begin
                        dec_phase = PH_LENGTH;
                    end
                end
            end
        endcase
    endtask

    // Byte driver: predict at acceptance, then offer the next item
    always @(posedge clk)
    begin : byte_driver
        byte_item_t nxt;
        if (!rst_n)
        begin
            byte_if.valid <= 1'b0;
            byte_if.operation <= OP_DATA;
            byte_if.data_byte <= 8'h00;
        end
        else
        begin
            if (byte_if.valid && byte_if.ready)
            begin
                step_decoder(byte_if.operation, byte_if.data_byte);
                items_taken++;
            end
            if (!byte_if.valid || byte_if.ready)
            begin
                if (feed_q.size() != 0 && $urandom_range(99) >= src_idle_pct)
                begin
                    nxt = feed_q.pop_front();
                    byte_if.valid <= 1'b1;
                    byte_if.operation <= nxt.op;
                    byte_if.data_byte <= nxt.data;
                end
                else
                begin
                    byte_if.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin : result_monitor
        result_t want;
        if (!rst_n)
        begin
            res_if.ready <= 1'b0;
        end
        else
        begin
            if (res_if.valid && res_if.ready)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    report_mismatch($sformatf("result with nothing pending: kind %0d byte %02h",
                                              res_if.kind, res_if.content_byte));
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (res_if.kind !== want.kind)
                        report_mismatch($sformatf("kind %0d, want %0d",
                                                  res_if.kind, want.kind));
                    if (res_if.content_byte !== want.content_byte)
                        report_mismatch($sformatf("content byte %02h, want %02h",
                                                  res_if.content_byte, want.content_byte));
                    if (res_if.error_code !== want.error_code)
                        report_mismatch($sformatf("error code %0d, want %0d",
                                                  res_if.error_code, want.error_code));
                end
            end
            res_if.ready <= !sink_hold && ($urandom_range(99) >= snk_idle_pct);
        end
    end

    task automatic push_input(input logic op, input logic [7:0] b);
        byte_item_t it;
        it.op = op;
        it.data = b;
        feed_q.push_back(it);
        items_queued++;
    endtask

    task automatic queue_hex_chars(input int n);
        repeat (n)
            push_input(OP_DATA, hex_char(4'($urandom_range(15)), 1'($urandom_range(1))));
    endtask

    // Length line padded with leading zeros to width characters, then CR LF
    task automatic queue_line(input logic [31:0] len, input int width);
        for (int i = width - 1; i >= 0; i--)
            push_input(OP_DATA, hex_char(4'(len >> (4 * i)), 1'($urandom_range(1))));
        push_input(OP_DATA, CR_BYTE);
        push_input(OP_DATA, LF_BYTE);
    endtask

    task automatic queue_chunk(input int unsigned len, input int width);
        queue_line(len, width);
        repeat (len)
            push_input(OP_DATA, 8'($urandom_range(255)));
        // the trailing pair is unchecked, so vary it now and then
        if ($urandom_range(3) != 0)
        begin
            push_input(OP_DATA, CR_BYTE);
            push_input(OP_DATA, LF_BYTE);
        end
        else
        begin
            push_input(OP_DATA, 8'($urandom_range(255)));
            push_input(OP_DATA, 8'($urandom_range(255)));
        end
    endtask

    function automatic int unsigned pick_len();
        if ($urandom_range(9) == 0)
            return $urandom_range(25, 200);
        return $urandom_range(1, 24);
    endfunction

    function automatic int pick_width(input int unsigned len);
        int nd;
        int unsigned v;
        nd = 0;
        v = len;
        while (v != 0)
        begin
            nd++;
            v = v >> 4;
        end
        if ($urandom_range(2) == 0)
            return $urandom_range(nd, 8);
        return nd;
    endfunction

    task automatic wait_drained();
        while (feed_q.size() != 0 || byte_if.valid || expected_results.size() != 0)
            @(negedge clk);
        // let a last item with no result settle inside the block
        repeat (4) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_limit(input logic [31:0] v);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        limit_cfg = v;
        limit_writes++;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
    endtask

    initial
    begin : timeout_guard
        #10_000_000;
        $display("simulation failed");
        $finish;
    end

    initial
    begin : stimulus
        int          ending;
        int          n;
        int          start;
        int          est;
        int unsigned len;
        int unsigned span;
        int unsigned lens[$];
        logic [7:0]  junk;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        write_limit(32'hFFFF_FFFF);

        // Directed: padded full-width line, extreme bytes, one-character line
        src_idle_pct = 23;
        snk_idle_pct = 54;
        push_input(OP_DATA, 8'h30);
        push_input(OP_DATA, 8'h30);
        push_input(OP_DATA, 8'h30);
        push_input(OP_DATA, 8'h30);
        push_input(OP_DATA, 8'h30);
        push_input(OP_DATA, 8'h30);
        push_input(OP_DATA, 8'h30);
        push_input(OP_DATA, 8'h32);
        push_input(OP_DATA, CR_BYTE);
        push_input(OP_DATA, LF_BYTE);
        push_input(OP_DATA, 8'hFF);
        push_input(OP_DATA, 8'h00);
        push_input(OP_DATA, CR_BYTE);
        push_input(OP_DATA, LF_BYTE);
        push_input(OP_DATA, 8'h31);
        push_input(OP_DATA, CR_BYTE);
        push_input(OP_DATA, LF_BYTE);
        push_input(OP_DATA, CR_BYTE);
        push_input(OP_DATA, 8'hFF);
        push_input(OP_DATA, 8'h00);

        start = items_queued;
        while (items_queued - start < 430)
        begin
            len = pick_len();
            queue_chunk(len, pick_width(len));
        end
        wait_drained();

        write_limit(body_count + 32'd1000 + 32'($urandom_range(0, 1 << 20)));
        src_idle_pct = 54;
        snk_idle_pct = 23;
        start = items_queued;
        while (items_queued - start < 430)
        begin
            len = pick_len();
            queue_chunk(len, pick_width(len));
        end
        wait_drained();

        // Tight limit: exactly what the next batch counts, so it just fits
        est = 0;
        span = 0;
        while (est < 430)
        begin
            len = pick_len();
            lens.push_back(len);
            span += len + 2;
            est += len + 6;
        end
        write_limit(body_count + span);
        src_idle_pct = 0;
        snk_idle_pct = 0;
        foreach (lens[i])
            queue_chunk(lens[i], pick_width(lens[i]));
        fork
            begin
                @(posedge clk);
                sink_hold <= 1'b1;
                repeat (400) @(posedge clk);
                sink_hold <= 1'b0;
            end
        join_none
        wait_drained();

        // End the body one way, then offer items the block must ignore
        src_idle_pct = 23;
        snk_idle_pct = 54;
        ending = $urandom_range(0, 8);
        case (ending)
            0:
                queue_chunk(0, $urandom_range(0, 8));
            1:
                queue_hex_chars(9);
            2:
            begin
                queue_hex_chars($urandom_range(0, 7));
                do
                    junk = 8'($urandom_range(255));
                while (hex_val(junk) >= 0 || junk == CR_BYTE);
                push_input(OP_DATA, junk);
            end
            3:
            begin
                queue_hex_chars($urandom_range(0, 8));
                push_input(OP_DATA, CR_BYTE);
                do
                    junk = 8'($urandom_range(255));
                while (junk == LF_BYTE);
                push_input(OP_DATA, junk);
            end
            4:
            begin
                n = $urandom_range(0, 3);
                if ($urandom_range(3) == 0)
                    write_limit(32'd0);
                else
                    write_limit(body_count + 32'(n));
                queue_chunk(n + 4, pick_width(n + 4));
            end
            5:
            begin
                queue_hex_chars($urandom_range(0, 8));
                push_input(OP_END, 8'($urandom_range(255)));
            end
            6:
            begin
                queue_line(32'd10, $urandom_range(1, 8));
                repeat ($urandom_range(0, 9))
                    push_input(OP_DATA, 8'($urandom_range(255)));
                push_input(OP_END, 8'($urandom_range(255)));
            end
            7:
            begin
                len = pick_len();
                queue_line(len, pick_width(len));
                repeat (len)
                    push_input(OP_DATA, 8'($urandom_range(255)));
                push_input(OP_DATA, CR_BYTE);
                push_input(OP_END, 8'($urandom_range(255)));
            end
            default:
            begin
                queue_line(32'hFFFF_FFFF, 8);
                repeat (5)
                    push_input(OP_DATA, 8'($urandom_range(255)));
                push_input(OP_END, 8'($urandom_range(255)));
            end
        endcase
        repeat (40)
            push_input(1'($urandom_range(1)), 8'($urandom_range(255)));
        wait_drained();

        $display("Covered %0d items in, %0d results out, %0d limit writes.",
                 items_taken, results_seen, limit_writes);
        $display("Body ending variant %0d, decoder left in %s after %0d counted bytes.",
                 ending, dec_phase.name(), body_count);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
